FILE: src/ordered_list_insert_remove_unit_defines.svh
// Assertion macros shared by the ordered list unit.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef ORDERED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// same-cycle implication
`define OLIR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olir assertion failed");

// next-cycle implication
`define OLIR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olir assertion failed");

`endif

FILE: src/olir_pkg.sv
// Shared types and constants for the ordered list unit.
// No dependencies.
package olir_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CNT_MAX   = 127;

	localparam logic [POS_W-1:0] CAP_RESET = 7'd64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic signed [DATA_W-1:0] BAD_READ = -32'sd99;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

FILE: src/olir_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on olir_pkg for field widths.
interface olir_req_if;
	import olir_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	modport source (output valid, opcode, position, value, input ready);
	modport sink (input valid, opcode, position, value, output ready);
endinterface

interface olir_rsp_if;
	import olir_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0]         count;
	logic                     is_full;
	logic                     is_empty;
	modport source (output valid, status, read_value, count, is_full, is_empty, input ready);
	modport sink (input valid, status, read_value, count, is_full, is_empty, output ready);
endinterface

FILE: src/ordered_list_insert_remove_unit.sv
// Top level of the ordered list unit: control, row of cells, read tree.
// Depends on olir_pkg, olir_if, olir_cell and the assertion header.
//
//   channel | dir | handshake        | carries
//   req     | in  | valid/ready      | opcode, position, value
//   rsp     | out | valid/ready      | status, read_value, count, is_full, is_empty
//   cfg     | in  | cfg_wr_en        | capacity (7 bits)
//
// One request at a time: an accepted request is held in the s1 registers beside
// the registered 8-way OR groups of the read tree, and the response register loads
// from s1, so no new request is taken while one is still held there.
// All cells shift in the accept cycle, so inserts and removes cost nothing extra.
// A stalled response holds the next request off until it is taken.
// arst_n clears count, capacity (to 64) and handshake state; entries stay unset.
`include "ordered_list_insert_remove_unit_defines.svh"
module ordered_list_insert_remove_unit #(
	parameter int unsigned DEPTH = olir_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [olir_pkg::POS_W-1:0]  cfg_wr_data,
	olir_req_if.sink                    req,
	olir_rsp_if.source                  rsp
);
	import olir_pkg::*;

	// count is 7 bits wide, so no more slots than it can address
	localparam int unsigned NCELL = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
	localparam int unsigned NGRP  = (NCELL + 7) / 8;
	localparam logic [POS_W-1:0] CAP_LIMIT = POS_W'(NCELL);

	logic [POS_W-1:0] capacity_q;
	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] cap_eff;
	logic [POS_W-1:0] count_next;
	logic [1:0]       status_next;
	logic             acc;
	logic             ins_ok;
	logic             rem_ok;
	logic             rd_ok;
	logic             out_load;
	cell_cmd_t        cmd;

	logic             valid_s1;
	logic [1:0]       status_s1;
	logic [POS_W-1:0] count_s1;
	logic             full_s1;
	logic             empty_s1;
	logic             is_read_s1;
	logic             rd_ok_s1;
	logic signed [DATA_W-1:0] grp_s1 [NGRP];

	logic signed [DATA_W-1:0] cell_data [NCELL];
	logic signed [DATA_W-1:0] hit_data [NCELL];
	logic signed [DATA_W-1:0] grp_or [NGRP];
	logic signed [DATA_W-1:0] rd_word;

	logic                     out_valid_q;
	logic [1:0]               out_status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [POS_W-1:0]         out_count_q;
	logic                     out_full_q;
	logic                     out_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	assign cap_eff = (capacity_q > CAP_LIMIT) ? CAP_LIMIT : capacity_q;

	assign req.ready = !valid_s1 && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	assign ins_ok = (req.opcode == OP_INSERT) && (req.position <= count_q)
		&& (count_q < cap_eff);
	assign rem_ok = (req.opcode == OP_REMOVE) && (req.position < count_q);
	assign rd_ok  = (req.opcode == OP_READ) && (req.position < count_q);

	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		unique case (req.opcode)
			OP_INSERT: begin
				if (req.position > count_q) begin
					status_next = ST_INVALID;
				end else if (count_q >= cap_eff) begin
					status_next = ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!rem_ok) begin
					status_next = ST_INVALID;
				end else begin
					count_next = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (!rd_ok) begin
					status_next = ST_INVALID;
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	assign cmd.ins   = acc && ins_ok;
	assign cmd.rem   = acc && rem_ok;
	assign cmd.pos   = req.position;
	assign cmd.value = req.value;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		olir_cell #(.INDEX(i)) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit_data   (hit_data[i])
		);
	end

	// first level of the read tree: groups of eight cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < 8; k++) begin
				if (g * 8 + k < NCELL) begin
					grp_or[g] = grp_or[g] | hit_data[g * 8 + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			grp_s1     <= grp_or;
			status_s1  <= status_next;
			count_s1   <= count_next;
			full_s1    <= (count_next >= cap_eff);
			empty_s1   <= (count_next == '0);
			is_read_s1 <= (req.opcode == OP_READ);
			rd_ok_s1   <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				count_q  <= count_next;
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_word = rd_word | grp_s1[g];
		end
	end

	assign out_load = valid_s1 && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_s1;
			out_count_q  <= count_s1;
			out_full_q   <= full_s1;
			out_empty_q  <= empty_s1;
			if (!is_read_s1) begin
				out_value_q <= '0;
			end else if (rd_ok_s1) begin
				out_value_q <= rd_word;
			end else begin
				out_value_q <= BAD_READ;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_value_q;
	assign rsp.count      = out_count_q;
	assign rsp.is_full    = out_full_q;
	assign rsp.is_empty   = out_empty_q;

	`OLIR_ASSERT_NEXT(a_acc_fills_s1, acc, valid_s1)
	`OLIR_ASSERT_NOW(a_one_in_flight, valid_s1, !req.ready)
	`OLIR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_LIMIT)
	`OLIR_ASSERT_NEXT(a_clear_empties, acc && req.opcode == OP_CLEAR, count_q == '0)

endmodule

FILE: src/olir_cell.sv
// One list slot: holds an entry and shifts with its neighbors on insert/remove.
// Depends on olir_pkg.
module olir_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                             clk,
	input  olir_pkg::cell_cmd_t              cmd,
	input  logic signed [olir_pkg::DATA_W-1:0] left_data,
	input  logic signed [olir_pkg::DATA_W-1:0] right_data,
	output logic signed [olir_pkg::DATA_W-1:0] data,
	output logic signed [olir_pkg::DATA_W-1:0] hit_data
);
	import olir_pkg::*;

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX == cmd.pos) begin
				data_q <= cmd.value;
			end else if (IDX > cmd.pos) begin
				data_q <= left_data;
			end
		end else if (cmd.rem && IDX >= cmd.pos) begin
			data_q <= right_data;
		end
	end

	assign data     = data_q;
	// masked for the OR-tree read
	assign hit_data = (IDX == cmd.pos) ? data_q : '0;

endmodule

FILE: verif/list_response_checker.sv
// Response checker for the ordered list unit: keeps its own copy of the list,
// predicts every response and compares it with what the unit returns.
// Depends on olir_pkg and the channel interfaces in olir_if.
module list_response_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [olir_pkg::POS_W-1:0] cfg_wr_data,
	olir_req_if        req,
	olir_rsp_if        rsp,
	output int         errors,
	output int         pending
);
	import olir_pkg::*;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0]         count;
		logic                     is_full;
		logic                     is_empty;
	} list_rsp_t;

	logic signed [DATA_W-1:0] list_mem [DEPTH_DEF];
	int                       list_len;
	logic [POS_W-1:0]         capacity;
	list_rsp_t                rsp_q[$];
	int                       fail_cnt;

	// applies one request to the shadow list and returns the response it earns
	function automatic list_rsp_t apply_request(input logic [1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_rsp_t r;
		int        lim;
		int        i;
		lim = (capacity > DEPTH_DEF) ? DEPTH_DEF : int'(capacity);
		r.status = ST_OK;
		r.read_value = '0;
		case (op)
		OP_INSERT: begin
			if (pos > list_len) begin
				r.status = ST_INVALID;
			end else if (list_len >= lim) begin
				r.status = ST_FULL;
			end else begin
				for (i = list_len; i > pos; i--)
					list_mem[i] = list_mem[i-1];
				list_mem[pos] = val;
				list_len++;
			end
		end
		OP_REMOVE: begin
			if (pos >= list_len) begin
				r.status = ST_INVALID;
			end else begin
				for (i = pos; i + 1 < list_len; i++)
					list_mem[i] = list_mem[i+1];
				list_len--;
			end
		end
		OP_READ: begin
			if (pos >= list_len) begin
				r.status = ST_INVALID;
				r.read_value = BAD_READ;
			end else begin
				r.read_value = list_mem[pos];
			end
		end
		default: begin
			list_len = 0;
		end
		endcase
		r.count = POS_W'(list_len);
		r.is_full = (list_len >= lim);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_rsp_t want;
		list_rsp_t got;
		if (!arst_n) begin
			rsp_q.delete();
			list_len = 0;
			capacity = CAP_RESET;
			fail_cnt = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.read_value, rsp.count, rsp.is_full, rsp.is_empty};
				if (rsp_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("checker: response with nothing outstanding: status=%0d value=%0d count=%0d",
							got.status, got.read_value, got.count);
				end else begin
					want = rsp_q.pop_front();
					if (got.status !== want.status || got.read_value !== want.read_value ||
							got.count !== want.count || got.is_full !== want.is_full ||
							got.is_empty !== want.is_empty) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display({"checker: mismatch: expected status=%0d value=%0d count=%0d",
								" full=%0b empty=%0b, got status=%0d value=%0d count=%0d",
								" full=%0b empty=%0b"},
								want.status, want.read_value, want.count, want.is_full,
								want.is_empty, got.status, got.read_value, got.count,
								got.is_full, got.is_empty);
					end
				end
			end
			if (req.valid && req.ready)
				rsp_q.push_back(apply_request(req.opcode, req.position, req.value));
			pending <= rsp_q.size();
			errors <= fail_cnt;
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the ordered list unit testbench: clock, reset, capacity writes, request
// stimulus and response backpressure; the verdict comes from list_response_checker.
// Depends on olir_pkg, olir_if, the unit itself and list_response_checker.
module testbench;
	import olir_pkg::*;

	typedef enum int {GROW, SHRINK, CHURN} mix_t;

	localparam int NUM_PHASES  = 13;
	localparam int PHASE_ITEMS = 148;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [POS_W-1:0] cfg_wr_data;
	int               errors;
	int               pending;

	// steering state for stimulus only
	int               fill_len;
	int               cap_now;
	bit               calm;
	int               stall_asks;
	int               stall_seen;

	olir_req_if req_ch ();
	olir_rsp_if rsp_ch ();

	ordered_list_insert_remove_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	list_response_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.pending     (pending)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end

	task automatic send_req(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int lim;
		if (!calm && $urandom_range(99) < 6) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.position <= pos;
		req_ch.value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		lim = (cap_now > DEPTH_DEF) ? DEPTH_DEF : cap_now;
		if (op == OP_INSERT && pos <= fill_len && fill_len < lim)
			fill_len++;
		else if (op == OP_REMOVE && pos < fill_len)
			fill_len--;
		else if (op == OP_CLEAR)
			fill_len = 0;
	endtask

	// drop valid and wait for every outstanding request to be answered
	task automatic finish_phase();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [POS_W-1:0] c);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_now = c;
	endtask

	function automatic logic [1:0] pick_op(input mix_t m);
		int r;
		int ins_w;
		int rem_w;
		r = $urandom_range(99);
		case (m)
		GROW: begin
			ins_w = 65;
			rem_w = 15;
		end
		SHRINK: begin
			ins_w = 15;
			rem_w = 60;
		end
		default: begin
			ins_w = 35;
			rem_w = 30;
		end
		endcase
		if (r < ins_w)
			return OP_INSERT;
		if (r < ins_w + rem_w)
			return OP_REMOVE;
		if (r < 97)
			return OP_READ;
		return OP_CLEAR;
	endfunction

	// mostly legal indexes, some just past the end, a few anywhere in the field
	function automatic logic [POS_W-1:0] pick_pos(input logic [1:0] op);
		int r;
		int hi;
		r = $urandom_range(99);
		hi = (op == OP_INSERT) ? fill_len : fill_len - 1;
		if (hi < 0)
			hi = 0;
		if (r < 85)
			return POS_W'($urandom_range(hi));
		if (r < 95)
			return POS_W'(fill_len + $urandom_range(3));
		return POS_W'($urandom_range(127));
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(39))
		0: return 32'sh7fffffff;
		1: return 32'sh80000000;
		2: return '0;
		3: return -32'sd1;
		default: return $urandom();
		endcase
	endfunction

	// response side: random backpressure, calm stretches, and long hold-offs on request
	initial begin
		int hold;
		hold = 0;
		stall_seen = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_asks) begin
				stall_seen = stall_asks;
				hold = $urandom_range(250, 150);
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		int         ph;
		int         n;
		logic [1:0] op;
		logic [POS_W-1:0] phase_cap;
		mix_t       phase_mix;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_READ;
		req_ch.position <= '0;
		req_ch.value <= '0;
		fill_len = 0;
		cap_now = CAP_RESET;
		calm = 0;
		stall_asks = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, signed extremes, boundaries of the index, clear
		send_req(OP_READ, 0, 0);
		send_req(OP_REMOVE, 0, 0);
		send_req(OP_INSERT, 1, 5);
		send_req(OP_INSERT, 0, 32'sh7fffffff);
		send_req(OP_INSERT, 0, 32'sh80000000);
		send_req(OP_INSERT, 2, -32'sd1);
		send_req(OP_INSERT, 1, 0);
		for (n = 0; n < 4; n++)
			send_req(OP_READ, POS_W'(n), 0);
		send_req(OP_READ, 4, 0);
		send_req(OP_READ, 127, 0);
		send_req(OP_REMOVE, 127, 0);
		send_req(OP_REMOVE, 1, 0);
		send_req(OP_READ, 1, 0);
		send_req(OP_CLEAR, 0, 0);
		send_req(OP_CLEAR, 0, 0);
		finish_phase();

		// full list; bad index on a full list must win over full
		write_capacity(2);
		send_req(OP_INSERT, 0, 11);
		send_req(OP_INSERT, 1, 22);
		send_req(OP_INSERT, 0, 33);
		send_req(OP_INSERT, 9, 44);
		finish_phase();

		// capacity dropped under the count
		write_capacity(1);
		send_req(OP_INSERT, 0, 55);
		send_req(OP_REMOVE, 0, 0);
		send_req(OP_REMOVE, 0, 0);
		finish_phase();

		// zero capacity: always full, full and empty together
		write_capacity(0);
		send_req(OP_INSERT, 0, 66);
		send_req(OP_READ, 0, 0);
		finish_phase();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
			0: begin
				phase_cap = 7'd64;
				phase_mix = GROW;
			end
			1: begin
				phase_cap = 7'd127;
				phase_mix = GROW;
			end
			2: begin
				phase_cap = 7'd64;
				phase_mix = CHURN;
			end
			3: begin
				phase_cap = 7'd3;
				phase_mix = SHRINK;
			end
			4: begin
				phase_cap = 7'd0;
				phase_mix = CHURN;
			end
			5: begin
				phase_cap = 7'd1;
				phase_mix = CHURN;
			end
			6: begin
				phase_cap = 7'd2;
				phase_mix = GROW;
			end
			7: begin
				phase_cap = 7'd65;
				phase_mix = GROW;
			end
			default: begin
				phase_cap = POS_W'($urandom_range(127, 1));
				phase_mix = mix_t'($urandom_range(2));
			end
			endcase
			write_capacity(phase_cap);
			calm = (ph == 0);
			if (ph == 1 || ph == 9)
				stall_asks++;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				op = pick_op(phase_mix);
				send_req(op, pick_pos(op), pick_value());
			end
			finish_phase();
		end

		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/olir_pkg.sv
src/olir_if.sv
src/olir_cell.sv
src/ordered_list_insert_remove_unit.sv
verif/list_response_checker.sv
verif/testbench.sv
